// ----- hw/rtl/mmgs_pkg.sv -----
// Package for the min-max gray stretch block.
// Holds the transaction structs, opcodes, sequencer states and divider constants.
// No dependencies.
package mmgs_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_MEASURE = 2'd1,
    OP_NORM    = 2'd2,
    OP_UNUSED  = 2'd3
  } mmgs_op_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] pixel;
  } mmgs_in_t;

  typedef struct packed {
    logic [16:0] norm_value;
    logic        flat_error;
  } mmgs_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } mmgs_state_t;

  localparam int QuoBits = 17;
  localparam int CntBits = $clog2(QuoBits);
  localparam logic [7:0] MinReset = 8'd255;
  localparam logic [7:0] MaxReset = 8'd0;
  localparam logic [16:0] ScaleByte = 17'd255;
  localparam logic [16:0] ScaleFrac = 17'd65536;

endpackage

// ----- hw/rtl/min_max_gray_stretch.sv -----
// Top level of the min-max gray stretch block.
// Depends on mmgs_pkg for transaction structs, opcodes and sequencer states.
// Usage:
//   in channel (in_valid/in_ready/in_data) carries an opcode and a pixel.
//   Clear resets the stored minimum to 255 and maximum to 0, measure folds
//   the pixel into them; neither gives a result. Normalize gives one result
//   on the out channel (out_valid/out_ready/out_data): the stretched level
//   and a flat-range flag.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes output_mode, always
//   ready; the user writes it only while the block is idle (not enforced).
// Sequencing:
//   A normalize that needs a division runs a radix-2 restoring divider,
//   one quotient bit per cycle for all 17 quotient bits, then loads the
//   output register once it is free; only then is the next transaction
//   accepted. Flat range, pixel at or below the minimum and saturated
//   pixels skip the divider and go straight to the output register load.
//   The input is not ready while a normalize is in progress.
// Reset: statistics return to min 255 / max 0, output_mode to 0, no result.
// Stall: a waiting result holds in the output register; the next item is
//   accepted and a following division runs, then holds until the slot frees.
module min_max_gray_stretch
  import mmgs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  mmgs_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output mmgs_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  mmgs_state_t state, state_next;

  logic               output_mode;
  logic [7:0]         min_level;
  logic [7:0]         max_level;
  logic [7:0]         range;
  logic [7:0]         rem;
  logic [QuoBits-1:0] num_low;
  logic [QuoBits-1:0] quo;
  logic               flat;
  logic [CntBits-1:0] count;

  logic        in_fire;
  logic        out_load;
  logic        is_norm;
  logic        fast;
  logic        flat_now;
  logic [7:0]  range_now;
  logic [7:0]  diff_now;
  logic [16:0] fast_value;
  logic [23:0] numer;
  logic [8:0]  rem_shift;
  logic        quo_bit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_norm   = (in_data.opcode == OP_NORM);

  assign flat_now  = (max_level <= min_level);
  assign range_now = max_level - min_level;
  assign diff_now  = in_data.pixel - min_level;

  always_comb begin
    fast       = 1'b1;
    fast_value = '0;
    if (flat_now || (in_data.pixel <= min_level)) begin
      fast_value = '0;
    end else if (diff_now >= range_now) begin
      fast_value = output_mode ? ScaleFrac : ScaleByte;
    end else begin
      fast = 1'b0;
    end
  end

  assign numer = output_mode ? {diff_now, 16'd0}
                             : ({8'd0, diff_now, 8'd0} - {16'd0, diff_now});

  assign rem_shift = {rem, num_low[QuoBits-1]};
  assign quo_bit   = (rem_shift >= {1'b0, range});
  assign out_load  = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && is_norm) begin
          state_next = fast ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (count == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode <= 1'b0;
      min_level   <= MinReset;
      max_level   <= MaxReset;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        output_mode <= cfg_data;
      end
      if (in_fire) begin
        unique case (in_data.opcode)
          OP_CLEAR: begin
            min_level <= MinReset;
            max_level <= MaxReset;
          end
          OP_MEASURE: begin
            if (in_data.pixel > max_level) begin
              max_level <= in_data.pixel;
            end
            if (in_data.pixel < min_level) begin
              min_level <= in_data.pixel;
            end
          end
          OP_NORM, OP_UNUSED: ;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_norm) begin
      flat    <= flat_now;
      range   <= range_now;
      quo     <= fast_value;
      rem     <= {1'b0, numer[23:QuoBits]};
      num_low <= numer[QuoBits-1:0];
      count   <= CntBits'(QuoBits - 1);
    end else if (state == ST_DIV) begin
      rem     <= quo_bit ? 8'(rem_shift - {1'b0, range}) : rem_shift[7:0];
      quo     <= {quo[QuoBits-2:0], quo_bit};
      num_low <= {num_low[QuoBits-2:0], 1'b0};
      count   <= count - 1'b1;
    end
    if (out_load) begin
      out_data.norm_value <= quo;
      out_data.flat_error <= flat;
    end
  end

endmodule

// ----- dv/tb_min_max_gray_stretch.sv -----
// Testbench for min_max_gray_stretch: a directed table, then random clear/measure/normalize
// sequences mostly under random idling; each result checked against its row or a predictor.
// Depends on mmgs_pkg and the min_max_gray_stretch RTL.
module tb_min_max_gray_stretch;
  import mmgs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 30;
  localparam int CycleLimit  = 500000;
  localparam int NumRows     = 27;
  localparam int PrintCap    = 100;

  typedef struct {
    bit          cfg_row;
    bit          mode;
    mmgs_op_t    op;
    logic [7:0]  pixel;
    bit          typed;
    logic [16:0] want_value;
    bit          want_flat;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  mmgs_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  mmgs_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  bit        row_typed = 1'b0;
  mmgs_out_t row_want = '0;

  logic [7:0] stat_min = MinReset;
  logic [7:0] stat_max = MaxReset;
  bit         frac_mode = 1'b0;
  mmgs_out_t  level_q[$];

  int gap_pct = 28;
  int stall_pct = 28;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int items_sent = 0;

  stim_row_t dir_rows [NumRows] = '{
    '{0, 0, OP_NORM,    8'd100, 1, 17'd0,     1},
    '{0, 0, OP_MEASURE, 8'd0,   0, 17'd0,     0},
    '{0, 0, OP_MEASURE, 8'd255, 0, 17'd0,     0},
    '{0, 0, OP_NORM,    8'd0,   1, 17'd0,     0},
    '{0, 0, OP_NORM,    8'd255, 1, 17'd255,   0},
    '{0, 0, OP_NORM,    8'd128, 1, 17'd128,   0},
    '{0, 0, OP_NORM,    8'd1,   1, 17'd1,     0},
    '{0, 0, OP_UNUSED,  8'd77,  0, 17'd0,     0},
    '{0, 0, OP_NORM,    8'd254, 1, 17'd254,   0},
    '{0, 0, OP_CLEAR,   8'd0,   0, 17'd0,     0},
    '{0, 0, OP_MEASURE, 8'd50,  0, 17'd0,     0},
    '{0, 0, OP_NORM,    8'd50,  1, 17'd0,     1},
    '{0, 0, OP_MEASURE, 8'd150, 0, 17'd0,     0},
    '{0, 0, OP_NORM,    8'd20,  1, 17'd0,     0},
    '{0, 0, OP_NORM,    8'd200, 1, 17'd255,   0},
    '{0, 0, OP_NORM,    8'd100, 0, 17'd0,     0},
    '{0, 0, OP_UNUSED,  8'd255, 0, 17'd0,     0},
    '{0, 0, OP_NORM,    8'd149, 0, 17'd0,     0},
    '{0, 0, OP_CLEAR,   8'd255, 0, 17'd0,     0},
    '{0, 0, OP_NORM,    8'd0,   1, 17'd0,     1},
    '{1, 1, OP_CLEAR,   8'd0,   0, 17'd0,     0},
    '{0, 0, OP_MEASURE, 8'd10,  0, 17'd0,     0},
    '{0, 0, OP_MEASURE, 8'd20,  0, 17'd0,     0},
    '{0, 0, OP_NORM,    8'd20,  1, 17'd65536, 0},
    '{0, 0, OP_NORM,    8'd10,  1, 17'd0,     0},
    '{0, 0, OP_NORM,    8'd15,  1, 17'd32768, 0},
    '{0, 0, OP_NORM,    8'd11,  0, 17'd0,     0}
  };

  min_max_gray_stretch u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL min_max_gray_stretch");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < PrintCap) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  function automatic bit predict_stretch(input mmgs_in_t item, output mmgs_out_t res);
    logic [31:0] scale;
    logic [31:0] diff;
    logic [31:0] span;
    res = '0;
    predict_stretch = 1'b0;
    case (mmgs_op_t'(item.opcode))
      OP_CLEAR: begin
        stat_min = MinReset;
        stat_max = MaxReset;
      end
      OP_MEASURE: begin
        if (item.pixel > stat_max) stat_max = item.pixel;
        if (item.pixel < stat_min) stat_min = item.pixel;
      end
      OP_NORM: begin
        predict_stretch = 1'b1;
        if (stat_max <= stat_min) begin
          res.flat_error = 1'b1;
        end else begin
          scale = frac_mode ? 32'd65536 : 32'd255;
          span = 32'(stat_max) - 32'(stat_min);
          if (item.pixel > stat_min) begin
            diff = 32'(item.pixel) - 32'(stat_min);
            if (diff >= span) res.norm_value = scale[16:0];
            else res.norm_value = 17'((scale * diff) / span);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    mmgs_out_t res;
    mmgs_out_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) frac_mode = cfg_data;
      if (in_valid && in_ready) begin
        if (predict_stretch(in_data, res)) level_q.push_back(row_typed ? row_want : res);
      end
      if (out_valid && out_ready) begin
        if (level_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d flat=%0d",
                                    out_data.norm_value, out_data.flat_error));
        end else begin
          want = level_q.pop_front();
          if (out_data.norm_value !== want.norm_value)
            report_mismatch($sformatf("norm_value got %0d want %0d",
                                      out_data.norm_value, want.norm_value));
          if (out_data.flat_error !== want.flat_error)
            report_mismatch($sformatf("flat_error got %0d want %0d",
                                      out_data.flat_error, want.flat_error));
        end
      end
    end
  end

  task automatic send_item(input mmgs_in_t item, input bit typed, input mmgs_out_t want);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid  <= 1'b1;
    in_data   <= item;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (!in_ready);
    if (mmgs_op_t'(item.opcode) != OP_UNUSED) items_sent++;
  endtask

  task automatic send_op(input mmgs_op_t op, input logic [7:0] pix);
    mmgs_in_t item;
    item.opcode = op;
    item.pixel  = pix;
    send_item(item, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (level_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int budget);
    int stop_at;
    int kind;
    int lo;
    int hi;
    int span;
    int n_meas;
    int n_norm;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 82) begin
        if (kind >= 12) send_op(OP_CLEAR, 8'($urandom_range(255)));
        lo = $urandom_range(255);
        case ($urandom_range(3))
          0: span = 0;
          1: span = $urandom_range(1, 4);
          2: span = $urandom_range(255);
          default: span = 255 - lo;
        endcase
        hi = (lo + span > 255) ? 255 : lo + span;
        n_meas = $urandom_range(1, 6);
        for (int i = 0; i < n_meas; i++) begin
          if (i == 0) send_op(OP_MEASURE, 8'(lo));
          else if (i == 1) send_op(OP_MEASURE, 8'(hi));
          else send_op(OP_MEASURE, 8'($urandom_range(hi, lo)));
        end
        n_norm = $urandom_range(1, 8);
        for (int i = 0; i < n_norm; i++) begin
          if ($urandom_range(99) < 70) send_op(OP_NORM, 8'($urandom_range(hi, lo)));
          else send_op(OP_NORM, 8'($urandom_range(255)));
        end
      end else begin
        repeat ($urandom_range(1, 4))
          send_op(mmgs_op_t'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    mmgs_in_t  item;
    mmgs_out_t want;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_row) begin
        write_mode(dir_rows[i].mode);
      end else begin
        item.opcode     = dir_rows[i].op;
        item.pixel      = dir_rows[i].pixel;
        want.norm_value = dir_rows[i].want_value;
        want.flat_error = dir_rows[i].want_flat;
        send_item(item, dir_rows[i].typed, want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_mode(ph % 2);
      if (ph == 4) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = 28;
        stall_pct = 28;
      end
      if (ph == 2) begin
        run_phase(125);
        wait_drained();
        run_phase(125);
      end else begin
        run_phase(250);
      end
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("PASS min_max_gray_stretch");
    end else begin
      $display("FAIL min_max_gray_stretch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mmgs_pkg.sv
hw/rtl/min_max_gray_stretch.sv
dv/tb_min_max_gray_stretch.sv
